/* hw/rtl/blr_pkg.sv */
package blr_pkg;

  // Fixed field widths of the item formats.
  localparam int LEVEL_W = 4;
  localparam int KIND_W  = 2;
  localparam int COUNT_W = 5;
  localparam int MASK_W  = 16;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_LEVELS = 16;
  localparam int DEF_INDEX_BITS = 20;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD    = 2'd0,
    KIND_ATTEMPT = 2'd1,
    KIND_CHECK   = 2'd2
  } kind_t;

  // Write enables of the level store.
  typedef struct packed {
    logic bnd_we;
    logic att_we;
  } mem_ctl_t;

endpackage

/* hw/rtl/blr_in_if.sv */
interface blr_in_if #(
  parameter int INDEX_BITS = blr_pkg::DEF_INDEX_BITS
);
  logic                                 valid;
  logic                                 ready;
  logic [blr_pkg::KIND_W-1:0]           kind;
  logic [blr_pkg::LEVEL_W-1:0]          level;
  logic signed [INDEX_BITS:0]           cand_index;
  logic [INDEX_BITS-1:0]                low_bound;
  logic [INDEX_BITS:0]                  high_bound;

  modport source (output valid, kind, level, cand_index, low_bound, high_bound,
                  input ready);
  modport sink (input valid, kind, level, cand_index, low_bound, high_bound,
                output ready);
endinterface

/* hw/rtl/blr_out_if.sv */
interface blr_out_if;
  logic                          valid;
  logic                          ready;
  logic                          all_done;
  logic [blr_pkg::COUNT_W-1:0]   rollback_cnt;
  logic [blr_pkg::MASK_W-1:0]    completed_mask;

  modport source (output valid, all_done, rollback_cnt, completed_mask,
                  input ready);
  modport sink (input valid, all_done, rollback_cnt, completed_mask,
                output ready);
endinterface

/* hw/rtl/blr_level_store.sv */
module blr_level_store #(
  parameter int MAX_LEVELS = blr_pkg::DEF_MAX_LEVELS,
  parameter int INDEX_BITS = blr_pkg::DEF_INDEX_BITS,
  parameter int AW         = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1
) (
  input  logic                  clk,
  input  blr_pkg::mem_ctl_t     ctl,
  input  logic [AW-1:0]         wr_addr,
  input  logic [AW-1:0]         rd_addr,
  input  logic [INDEX_BITS:0]   wr_att,
  input  logic [INDEX_BITS-1:0] wr_low,
  input  logic [INDEX_BITS:0]   wr_high,
  output logic [INDEX_BITS:0]   rd_att,
  output logic [INDEX_BITS-1:0] rd_low,
  output logic [INDEX_BITS:0]   rd_high
);
  import blr_pkg::*;

  localparam int IW = INDEX_BITS + 1;
  localparam int BW = INDEX_BITS + IW;

  // Last attempted index per level, and the {high, low} bounds per level.
  logic [IW-1:0] att_mem [MAX_LEVELS];
  logic [BW-1:0] bnd_mem [MAX_LEVELS];
  logic [BW-1:0] bnd_q;

  always_ff @(posedge clk) begin
    if (ctl.att_we) begin
      att_mem[wr_addr] <= wr_att;
    end
    if (ctl.bnd_we) begin
      bnd_mem[wr_addr] <= {wr_high, wr_low};
    end
    rd_att <= att_mem[rd_addr];
    bnd_q  <= bnd_mem[rd_addr];
  end

  assign rd_low  = bnd_q[INDEX_BITS-1:0];
  assign rd_high = bnd_q[BW-1:INDEX_BITS];

endmodule

/* hw/rtl/backtrack_level_rollback.sv */
// Backtracking level rollback keeps the control state of a depth-first search
// whose levels each run over their own candidate range, much like an odometer.
// A load item stores the range [low_bound, high_bound) of one level and primes
// its last attempted index to low_bound - 1 (level 0 is primed to low_bound and
// also returns the current level to 0). An attempt item records the candidate
// index tried at a level and makes that level current. A check item walks from
// the current level down toward level 0; every level whose last attempt equals
// high_bound - 1 is reported in completed_mask and reprimed, and the walk stops
// at the first level that still has candidates left. Only check items produce a
// result item. Load and attempt items leave the block idle. A check is accepted,
// then walks the levels (the walk reads one level a cycle from the level store,
// whose read data is registered), then places its result; a result that is not
// yet taken holds a finishing check until the output register frees. Loads or
// attempts at levels at or beyond MAX_LEVELS, and items of kind 3, are dropped.
// The store comes out of reset unwritten: a check must not reach a level that
// was never loaded or attempted.
module backtrack_level_rollback #(
  parameter int MAX_LEVELS = blr_pkg::DEF_MAX_LEVELS,
  parameter int INDEX_BITS = blr_pkg::DEF_INDEX_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  blr_in_if.sink    in_chan,
  blr_out_if.source out_chan
);
  import blr_pkg::*;

  localparam int AW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int IW = INDEX_BITS + 1;
  localparam int XW = IW + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  state_t               state_r;
  logic [LEVEL_W-1:0]   cur_level_r;
  logic [LEVEL_W-1:0]   walk_lvl_r;
  logic [COUNT_W-1:0]   count_r;
  logic [MASK_W-1:0]    mask_r;

  logic                 out_valid_r;
  logic                 out_done_r;
  logic [COUNT_W-1:0]   out_count_r;
  logic [MASK_W-1:0]    out_mask_r;

  mem_ctl_t             mem_ctl;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;
  logic [IW-1:0]        wr_att;
  logic [IW-1:0]        rd_att;
  logic [INDEX_BITS-1:0] rd_low;
  logic [IW-1:0]        rd_high;

  logic                 accept;
  logic                 lvl_ok;
  logic [IW-1:0]        low_ext;
  logic [IW-1:0]        rd_low_m1;
  logic                 level_finished;
  logic                 out_free;

  // The block takes items only between checks.
  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign lvl_ok        = (32'(in_chan.level) < MAX_LEVELS);
  assign low_ext       = {1'b0, in_chan.low_bound};
  assign rd_low_m1     = {1'b0, rd_low} - IW'(1);

  // A level is finished when its last attempt sits on its last candidate.
  // The compare runs one bit wider than the store, with the attempt sign
  // extended and the high bound zero extended, so an empty range matches -1
  // while a high bound above the index range matches no attempt at all.
  assign level_finished = ({rd_att[IW-1], rd_att} == ({1'b0, rd_high} - XW'(1)));

  assign out_free = !out_valid_r || out_chan.ready;

  // Store port control. While idle the write port serves load and attempt
  // items and the read port keeps looking at the current level, so a check
  // finds that level's data ready in the cycle after it is accepted. During
  // the walk the write port reprimes the level just examined while the read
  // port already fetches the level below; the two never address one entry.
  always_comb begin
    mem_ctl = '0;
    wr_addr = AW'(in_chan.level);
    rd_addr = AW'(cur_level_r);
    wr_att  = $unsigned(in_chan.cand_index);
    case (state_r)
      S_IDLE: begin
        if (accept && lvl_ok) begin
          case (in_chan.kind)
            KIND_LOAD: begin
              mem_ctl.bnd_we = 1'b1;
              mem_ctl.att_we = 1'b1;
              wr_att = (in_chan.level == '0) ? low_ext : (low_ext - IW'(1));
            end
            KIND_ATTEMPT: begin
              mem_ctl.att_we = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        wr_addr        = AW'(walk_lvl_r);
        rd_addr        = AW'(walk_lvl_r - LEVEL_W'(1));
        wr_att         = rd_low_m1;
        mem_ctl.att_we = level_finished;
      end
      default: begin
      end
    endcase
  end

  blr_level_store #(
    .MAX_LEVELS (MAX_LEVELS),
    .INDEX_BITS (INDEX_BITS),
    .AW         (AW)
  ) u_store (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_addr (wr_addr),
    .rd_addr (rd_addr),
    .wr_att  (wr_att),
    .wr_low  (in_chan.low_bound),
    .wr_high (in_chan.high_bound),
    .rd_att  (rd_att),
    .rd_low  (rd_low),
    .rd_high (rd_high)
  );

  // Sequencer: current level, the walk over the levels and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_level_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // The result register empties when its item is taken, unless the
      // finishing check refills it in the same cycle.
      if (out_valid_r && out_chan.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (in_chan.kind)
              KIND_LOAD: begin
                if (lvl_ok && in_chan.level == '0) begin
                  cur_level_r <= '0;
                end
              end
              KIND_ATTEMPT: begin
                if (lvl_ok) begin
                  cur_level_r <= in_chan.level;
                end
              end
              KIND_CHECK: begin
                state_r    <= S_WALK;
                walk_lvl_r <= cur_level_r;
                count_r    <= '0;
                mask_r     <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_WALK: begin
          if (level_finished) begin
            count_r    <= count_r + COUNT_W'(1);
            mask_r     <= mask_r | (MASK_W'(1) << walk_lvl_r);
            walk_lvl_r <= walk_lvl_r - LEVEL_W'(1);
            if (walk_lvl_r == '0) begin
              state_r <= S_DONE;
            end
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_done_r  <= (count_r == (COUNT_W'(cur_level_r) + COUNT_W'(1)));
            out_count_r <= count_r;
            out_mask_r  <= mask_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.all_done       = out_done_r;
  assign out_chan.rollback_cnt   = out_count_r;
  assign out_chan.completed_mask = out_mask_r;

endmodule

/* tb/backtrack_level_rollback_tb.sv */
`timescale 1ns / 100ps

module backtrack_level_rollback_tb;
  import blr_pkg::*;

  localparam int NUM_LEVELS  = DEF_MAX_LEVELS;
  localparam int IDX_BITS    = DEF_INDEX_BITS;
  localparam int LOW_MAX     = (1 << IDX_BITS) - 1;
  localparam int HIGH_MAX    = 1 << IDX_BITS;
  localparam int TOTAL_ITEMS = 400;
  // A check walks at most every level, plus its acceptance and its result.
  localparam int WALK_CYCLES = NUM_LEVELS + 2;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 2000;
  localparam int REPORT_MAX  = 10;

  // Kind code that the block drops without a result.
  localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

  // One check result: completion flag, number of rolled-back levels, their mask.
  typedef struct {
    logic               done;
    logic [COUNT_W-1:0] count;
    logic [MASK_W-1:0]  mask;
  } rollback_result_t;

  // Tracks the search state of the block and the check results still owed.
  class rollback_tracker;
    int               last_try [NUM_LEVELS];
    int               range_lo [NUM_LEVELS];
    int               range_hi [NUM_LEVELS];
    int               cur_level;
    int               mismatches;
    rollback_result_t pending_rollbacks[$];

    function new();
      cur_level  = 0;
      mismatches = 0;
      foreach (last_try[i]) begin
        last_try[i] = 0;
        range_lo[i] = 0;
        range_hi[i] = 0;
      end
    endfunction

    function int pending();
      return pending_rollbacks.size();
    endfunction

    function void note_item(logic [KIND_W-1:0] kind, logic [LEVEL_W-1:0] level,
                            int cand, int lo, int hi);
      rollback_result_t res;
      int               lvl;
      bit               walking;
      lvl = int'(level);
      case (kind)
        KIND_LOAD: begin
          if (lvl < NUM_LEVELS) begin
            range_lo[lvl] = lo;
            range_hi[lvl] = hi;
            if (lvl == 0) begin
              last_try[0] = lo;
              cur_level   = 0;
            end else begin
              last_try[lvl] = lo - 1;
            end
          end
        end
        KIND_ATTEMPT: begin
          if (lvl < NUM_LEVELS) begin
            last_try[lvl] = cand;
            cur_level     = lvl;
          end
        end
        KIND_CHECK: begin
          res.count = '0;
          res.mask  = '0;
          walking   = 1'b1;
          // Walk down from the current level; stop at the first level with
          // candidates left, repriming every finished level on the way.
          for (int i = cur_level; i >= 0; i--) begin
            if (walking && last_try[i] == range_hi[i] - 1) begin
              res.mask[i] = 1'b1;
              last_try[i] = range_lo[i] - 1;
              res.count   = res.count + 1'b1;
            end else begin
              walking = 1'b0;
            end
          end
          res.done = (int'(res.count) == cur_level + 1);
          pending_rollbacks.push_back(res);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_rollback(logic done, logic [COUNT_W-1:0] count,
                                 logic [MASK_W-1:0] mask);
      rollback_result_t exp_res;
      if (pending_rollbacks.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result item: done=%0d count=%0d mask=%h",
                   done, count, mask);
        return;
      end
      exp_res = pending_rollbacks.pop_front();
      if (done !== exp_res.done || count !== exp_res.count ||
          mask !== exp_res.mask) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display({"result mismatch: expected done=%0d count=%0d mask=%h,",
                    " got done=%0d count=%0d mask=%h"},
                   exp_res.done, exp_res.count, exp_res.mask, done, count, mask);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  blr_in_if #(.INDEX_BITS(IDX_BITS)) in_ch();
  blr_out_if out_ch();

  backtrack_level_rollback #(
    .MAX_LEVELS(NUM_LEVELS),
    .INDEX_BITS(IDX_BITS)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_ch),
    .out_chan(out_ch)
  );

  rollback_tracker tracker;
  int              items_sent;
  bit              tx_gaps_on;
  bit              rx_gaps_on;
  int              rx_hold_req;

  // Free-running clock with a 4 ns period.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Gap lengths: mostly none, often short, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one item at the falling edge and holds it until the block takes it.
  // The tracker sees exactly the field values that crossed the handshake.
  task automatic send_item(logic [KIND_W-1:0] kind, logic [LEVEL_W-1:0] level,
                           int cand, int lo, int hi);
    int idle;
    @(negedge clk);
    in_ch.kind       = kind;
    in_ch.level      = level;
    in_ch.cand_index = cand[IDX_BITS:0];
    in_ch.low_bound  = lo[IDX_BITS-1:0];
    in_ch.high_bound = hi[IDX_BITS:0];
    in_ch.valid      = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    tracker.note_item(in_ch.kind, in_ch.level, in_ch.cand_index,
                      int'(in_ch.low_bound), int'(in_ch.high_bound));
    if (kind != KIND_RESERVED)
      items_sent++;
    // Valid stays high into the next item when no gap is drawn.
    if (tx_gaps_on) begin
      idle = gap_len();
      if (idle > 0) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
        repeat (idle - 1) @(negedge clk);
      end
    end
  endtask

  task automatic load_level(int lvl, int lo, int hi);
    send_item(KIND_LOAD, lvl[LEVEL_W-1:0], $urandom_range(0, HIGH_MAX) - 1, lo, hi);
  endtask

  task automatic try_candidate(int lvl, int cand);
    send_item(KIND_ATTEMPT, lvl[LEVEL_W-1:0], cand,
              $urandom_range(0, LOW_MAX), $urandom_range(0, HIGH_MAX));
  endtask

  task automatic check_levels();
    send_item(KIND_CHECK, LEVEL_W'($urandom_range(0, NUM_LEVELS - 1)),
              $urandom_range(0, HIGH_MAX) - 1,
              $urandom_range(0, LOW_MAX), $urandom_range(0, HIGH_MAX));
  endtask

  // Drops valid and waits until every owed result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Low bounds favor the two ends of the range now and then.
  function automatic int pick_low();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return LOW_MAX;
    return $urandom_range(0, LOW_MAX);
  endfunction

  // Candidate for a level: mostly its last one, so the walk goes deep, and
  // otherwise the primed value, minus one, or anything from -1 to HIGH_MAX - 1.
  function automatic int pick_index(int lvl);
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return tracker.range_hi[lvl] - 1;
    if (r == 7) return tracker.range_lo[lvl] - 1;
    if (r == 8) return -1;
    return $urandom_range(0, HIGH_MAX) - 1;
  endfunction

  // One well-formed search step: optionally reload the ranges of levels 0 up
  // to a chosen depth, try candidates level by level so that the deepest
  // level ends up current, then check one or more times.
  task automatic run_search_episode();
    int depth;
    int lo;
    int hi;
    int reps;
    depth = ($urandom_range(0, 3) == 0) ? NUM_LEVELS - 1 :
            $urandom_range(0, NUM_LEVELS - 1);
    if ($urandom_range(0, 2) == 0) begin
      for (int i = 0; i <= depth; i++) begin
        lo = pick_low();
        hi = lo + $urandom_range(0, 3);
        if (hi > HIGH_MAX) hi = HIGH_MAX;
        load_level(i, lo, hi);
      end
    end
    for (int i = 0; i < depth; i++) begin
      if ($urandom_range(0, 3) != 0)
        try_candidate(i, pick_index(i));
    end
    try_candidate(depth, pick_index(depth));
    reps = $urandom_range(1, 3);
    repeat (reps) check_levels();
  endtask

  // The receiver drives ready at the falling edge. A hold-off request from the
  // stimulus is counted down here, independent of what the sender is doing.
  initial begin
    int quiet;
    quiet = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        quiet       = rx_hold_req;
        rx_hold_req = 0;
      end
      if (quiet > 0) begin
        out_ch.ready = 1'b0;
        quiet--;
      end else begin
        out_ch.ready = 1'b1;
        if (rx_gaps_on)
          quiet = gap_len();
      end
    end
  end

  // Results are sampled at the rising edge where valid and ready are both high.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        tracker.check_rollback(out_ch.all_done, out_ch.rollback_cnt,
                               out_ch.completed_mask);
    end
  end

  // Watchdog: a long run of cycles with no handshake on either side means the
  // block has hung.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("backtrack_level_rollback regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int  lo;
    int  hi;
    int  r;
    bit  pressed;
    tracker          = new();
    items_sent       = 0;
    tx_gaps_on       = 1'b1;
    rx_gaps_on       = 1'b1;
    rx_hold_req      = 0;
    pressed          = 1'b0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = KIND_LOAD;
    in_ch.level      = '0;
    in_ch.cand_index = '0;
    in_ch.low_bound  = '0;
    in_ch.high_bound = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. Level 0 is loaded first: its index is primed to the low
    // bound, so a single-candidate range is finished right away, and a check
    // touches only level 0 while the current level is 0.
    load_level(0, 5, 6);
    check_levels();
    // An empty range makes high minus one equal to -1, which an attempt of -1
    // matches.
    load_level(0, 0, 0);
    try_candidate(0, -1);
    check_levels();
    // Load the remaining levels, some with the extremes of both bounds. Loads above
    // level 0 leave the current level alone.
    for (int lvl = 1; lvl < NUM_LEVELS; lvl++) begin
      case (lvl)
        15: begin lo = LOW_MAX; hi = HIGH_MAX; end
        14: begin lo = 0;       hi = HIGH_MAX; end
        13: begin lo = LOW_MAX; hi = 0;        end
        12: begin lo = 0;       hi = 0;        end
        default: begin lo = lvl * 3; hi = lvl * 3 + 1; end
      endcase
      load_level(lvl, lo, hi);
    end
    // The top level finishes on the largest index; level 14 was just primed
    // and stops the walk.
    try_candidate(NUM_LEVELS - 1, HIGH_MAX - 1);
    check_levels();
    // The reserved kind is dropped without a result.
    send_item(KIND_RESERVED, LEVEL_W'(NUM_LEVELS - 1), -1, LOW_MAX, HIGH_MAX);

    // Random part. Every level is written by now, so any check is legal.
    while (items_sent < TOTAL_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70)
        run_search_episode();
      else if (r < 80)
        load_level($urandom_range(0, NUM_LEVELS - 1), $urandom_range(0, LOW_MAX),
                   $urandom_range(0, HIGH_MAX));
      else if (r < 88)
        try_candidate($urandom_range(0, NUM_LEVELS - 1),
                      $urandom_range(0, HIGH_MAX) - 1);
      else if (r < 95)
        check_levels();
      else
        send_item(KIND_RESERVED, LEVEL_W'($urandom_range(0, NUM_LEVELS - 1)),
                  $urandom_range(0, HIGH_MAX) - 1, $urandom_range(0, LOW_MAX),
                  $urandom_range(0, HIGH_MAX));

      // Switch idling on and off so that some stretches run back to back.
      if ($urandom_range(0, 19) == 0) tx_gaps_on = ~tx_gaps_on;
      if ($urandom_range(0, 19) == 0) rx_gaps_on = ~rx_gaps_on;

      // Once, the receiver holds off for a long time while checks keep
      // coming, so the output register fills and the input stalls. The
      // sender then pauses until every result has been taken.
      if (!pressed && items_sent >= TOTAL_ITEMS / 2) begin
        pressed     = 1'b1;
        rx_hold_req = HOLD_CYCLES;
        repeat (6) check_levels();
        wait_drained();
      end else if ($urandom_range(0, 49) == 0) begin
        wait_drained();
      end
    end

    // Drain, then give the block time to produce anything it should not.
    wait_drained();
    repeat (2 * WALK_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("backtrack_level_rollback regression: pass");
    else
      $display("backtrack_level_rollback regression: fail");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/blr_pkg.sv
hw/rtl/blr_in_if.sv
hw/rtl/blr_out_if.sv
hw/rtl/blr_level_store.sv
hw/rtl/backtrack_level_rollback.sv
tb/backtrack_level_rollback_tb.sv
